@@ src/pmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_pkg: shared types and constants of the pose median filter
// window size, field widths, pose sample layout and lane value types
// ----------------------------------------------------------------------------
package pmf_pkg;

	localparam int WINDOW  = 5;               // samples in the median window, 3..9
	localparam int HIST    = WINDOW - 1;      // stored past samples
	localparam int MID     = WINDOW / 2;      // sorted index of the median (upper for even)
	localparam int RANK_W  = $clog2(WINDOW);  // holds a rank 0..WINDOW-1

	localparam int NPOS    = 3;
	localparam int NROT    = 4;
	localparam int NLANE   = NPOS + NROT;
	localparam int POS_W   = 32;
	localparam int ROT_W   = 16;
	localparam int LANE_W  = POS_W;           // lanes run at the widest field width

	// payload packed without gaps, first field lowest; already whole bytes
	localparam int TDATA_W = NPOS * POS_W + NROT * ROT_W;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [ROT_W-1:0]  rot_t;
	typedef logic signed [LANE_W-1:0] lane_t;

	typedef struct packed {
		rot_t [NROT-1:0] rot;   // w, x, y, z at index 0..3
		pos_t [NPOS-1:0] pos;   // x, y, z at index 0..2
	} pose_t;

	typedef pose_t [HIST-1:0] hist_t;   // entry 0 is the oldest sample
	typedef lane_t [WINDOW-1:0] win_t;

endpackage

@@ src/pmf_hist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_hist: pose history shift line
// keeps the last HIST accepted samples, cleared to zero by reset
// ----------------------------------------------------------------------------
module pmf_hist
	import pmf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  pose_t din,
	output hist_t hist
);

	hist_t hist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (shift) begin
			for (int k = 0; k < HIST - 1; k++) begin
				hist_q[k] <= hist_q[k+1];
			end
			hist_q[HIST-1] <= din;
		end
	end

	assign hist = hist_q;

endmodule

@@ src/pmf_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmf_lane: median of one component over the window
// stage 1 registers the pairwise compare matrix, then rank counting picks
// the element whose rank is the middle one
// ----------------------------------------------------------------------------
module pmf_lane
	import pmf_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  win_t  win,
	output lane_t med
);

	// prec[j][i]: element j sorts ahead of element i (ties broken by index)
	logic [WINDOW-1:0][WINDOW-1:0] prec;
	logic [WINDOW-1:0][WINDOW-1:0] prec_s1;
	win_t                          val_s1;
	logic [RANK_W-1:0]             rank;

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			for (int j = 0; j < WINDOW; j++) begin
				if (i == j) begin
					prec[j][i] = 1'b0;
				end else begin
					prec[j][i] = ($signed(win[j]) < $signed(win[i])) ||
						((win[j] == win[i]) && (j < i));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s1  <= win;
			prec_s1 <= prec;
		end
	end

	// ranks form a permutation, so exactly one element matches
	always_comb begin
		med  = '0;
		rank = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank = '0;
			for (int j = 0; j < WINDOW; j++) begin
				rank = rank + RANK_W'(prec_s1[j][i]);
			end
			if (rank == RANK_W'(MID)) begin
				med = med | val_s1[i];
			end
		end
	end

endmodule

@@ src/pose_median_of_five_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_median_of_five_filter_top: sliding window median of pose samples
// an accepted input beat goes through the compare and output registers
// throughput: one beat per cycle unless m_axis stalls, set by one compare
// stage and one rank/select stage per lane; all seven lanes work in parallel
// reset: arst_n clears the sample history to zeros and empties the pipeline
// ----------------------------------------------------------------------------
module pose_median_of_five_filter_top
	import pmf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input beat
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// pos_x[31:0] pos_y[63:32] pos_z[95:64] quat_w[111:96] quat_x[127:112]
	// quat_y[143:128] quat_z[159:144]
	input  logic [TDATA_W-1:0] s_axis_tdata,
	// result beat
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// med_pos_x[31:0] med_pos_y[63:32] med_pos_z[95:64] med_quat_w[111:96]
	// med_quat_x[127:112] med_quat_y[143:128] med_quat_z[159:144]
	output logic [TDATA_W-1:0] m_axis_tdata
);

	pose_t              in_pose;
	hist_t              hist;
	win_t               lane_win [NLANE];
	lane_t              lane_med [NLANE];
	logic [TDATA_W-1:0] out_pack;
	logic [TDATA_W-1:0] tdata_s2;
	logic               vld_s1;
	logic               vld_s2;
	logic               en_s1;
	logic               en_s2;
	logic               accept;

	// pipeline control: the output register frees when empty or taken,
	// the compare stage frees when empty or moving on
	assign en_s2         = !vld_s2 || m_axis_tready;
	assign en_s1         = !vld_s1 || en_s2;
	assign s_axis_tready = en_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// unpack the input beat
	always_comb begin
		for (int c = 0; c < NPOS; c++) begin
			in_pose.pos[c] = s_axis_tdata[c*POS_W +: POS_W];
		end
		for (int c = 0; c < NROT; c++) begin
			in_pose.rot[c] = s_axis_tdata[NPOS*POS_W + c*ROT_W +: ROT_W];
		end
	end

	// history only moves on an accepted beat
	pmf_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (accept),
		.din    (in_pose),
		.hist   (hist)
	);

	// build one window per component: stored samples plus the new one;
	// quaternion values are sign extended to lane width
	always_comb begin
		for (int c = 0; c < NPOS; c++) begin
			for (int k = 0; k < HIST; k++) begin
				lane_win[c][k] = hist[k].pos[c];
			end
			lane_win[c][HIST] = in_pose.pos[c];
		end
		for (int c = 0; c < NROT; c++) begin
			for (int k = 0; k < HIST; k++) begin
				lane_win[NPOS+c][k] = {{(LANE_W-ROT_W){hist[k].rot[c][ROT_W-1]}},
					hist[k].rot[c]};
			end
			lane_win[NPOS+c][HIST] = {{(LANE_W-ROT_W){in_pose.rot[c][ROT_W-1]}},
				in_pose.rot[c]};
		end
	end

	// one median lane per component
	for (genvar g = 0; g < NLANE; g++) begin : g_lane
		pmf_lane u_lane (
			.clk (clk),
			.en  (en_s1),
			.win (lane_win[g]),
			.med (lane_med[g])
		);
	end

	// merge the lane results into one beat; quaternion medians come back
	// to 16 bits (the sign extension made the upper bits redundant)
	always_comb begin
		for (int c = 0; c < NPOS; c++) begin
			out_pack[c*POS_W +: POS_W] = lane_med[c][POS_W-1:0];
		end
		for (int c = 0; c < NROT; c++) begin
			out_pack[NPOS*POS_W + c*ROT_W +: ROT_W] = lane_med[NPOS+c][ROT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en_s2) begin
			tdata_s2 <= out_pack;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = tdata_s2;

	// an accepted beat always lands in the compare stage
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_s1)
		else $error("accepted beat did not reach the compare stage");

	// a compare stage result moves into the free output register
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && en_s2) |=> vld_s2)
		else $error("compare stage result dropped");

	// a held compare stage keeps its median
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !en_s2) |=> (vld_s1 && $stable(out_pack)))
		else $error("held compare stage changed");

	// the newest history entry is the last accepted sample
	a_hist_newest: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (hist[HIST-1] == $past(in_pose)))
		else $error("history did not take the accepted sample");

endmodule
